>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, constants and helpers of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int DIM_W     = 4;   // width of a dimension register
    localparam int OUT_W     = 35;  // Q19.16 result width
    localparam int OUT_IDX_W = 3;   // row / col result index width
    localparam int REG_IDX_W = 2;   // configuration index width

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B     = 2'd2;

    // One multiply job: clamped dimensions
    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] inner;
        logic [DIM_W-1:0] cols;
    } t_job;

    // Zero acts as one, anything above the limit acts as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > lim) begin
            res = lim;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

>>> sv/matrix_multiply_engine.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Streaming GEMM: loads A then B element by element, then emits C row-major.
// ----------------------------------------------------------------------------
// Usage:
//   Configure rows_a, inner_size and cols_b through i_cfg_we / i_cfg_index /
//   i_cfg_data while idle; any write of a known register restarts loading.
//   Elements (Q8.8) are requested with start while busy is low, one per
//   cycle: A row-major (rows_a x inner_size), then B (inner_size x cols_b).
//   After the last B element busy rises the next cycle and stays high
//   through compute. Each C element (Q19.16, exact) appears for one cycle
//   with o_valid, o_row and o_col, and o_last on the final one.
//   Compute runs one multiply-accumulate per cycle in the back-end
//   pipeline, so each result is the sum of inner_size products.
//   Reset returns dimensions to 8 and loading to the first A element.
//   The receiver cannot stall; every result is taken in its cycle.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mme_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [ELEMENT_WIDTH-1:0]      i_element,
    output logic                          o_valid,
    output logic [mme_pkg::OUT_W-1:0]     o_product_element,
    output logic [mme_pkg::OUT_IDX_W-1:0] o_row,
    output logic [mme_pkg::OUT_IDX_W-1:0] o_col,
    output logic                          o_last
);
    import mme_pkg::*;
    `include "assert_macros.svh"

    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

    logic               accept;
    logic               a_we, b_we;
    logic [ADDR_W-1:0]  waddr, a_raddr, b_raddr;
    logic [ELEMENT_WIDTH-1:0] wdata, a_rdata, b_rdata;
    logic               job_valid, job_ready, back_busy;
    t_job               job;

    assign accept = start && !busy;
    assign busy   = job_valid || back_busy;

    // front end
    mme_loader #(.MAX_DIM(MAX_DIM), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_loader (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_element   (i_element),
        .o_a_we      (a_we),
        .o_b_we      (b_we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    // element stores
    mme_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mme_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // back end
    mme_compute #(.MAX_DIM(MAX_DIM), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_compute (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (job_valid),
        .o_job_ready       (job_ready),
        .i_job             (job),
        .o_a_raddr         (a_raddr),
        .o_b_raddr         (b_raddr),
        .i_a_rdata         (a_rdata),
        .i_b_rdata         (b_rdata),
        .o_busy            (back_busy),
        .o_valid           (o_valid),
        .o_product_element (o_product_element),
        .o_row             (o_row),
        .o_col             (o_col),
        .o_last            (o_last)
    );

    // checks
    `ASSERT_IMP(a_result_while_busy, i_clk, i_rst_n, o_valid, busy)
    `ASSERT_NEXT(a_quiet_after_last, i_clk, i_rst_n, o_valid && o_last, !o_valid)
    `ASSERT_IMP(a_no_store_write_in_compute, i_clk, i_rst_n, back_busy, !a_we && !b_we)
endmodule

>>> sv/mme_ram.sv
// ----------------------------------------------------------------------------
// mme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/mme_loader.sv
// ----------------------------------------------------------------------------
// mme_loader
// Front end: holds configuration, steers incoming elements into the A and B
// stores and queues a job once the last B element has arrived.
// ----------------------------------------------------------------------------
module mme_loader #(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mme_pkg::REG_IDX_W-1:0]     i_cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic                              i_accept,
    input  logic [ELEMENT_WIDTH-1:0]          i_element,
    output logic                              o_a_we,
    output logic                              o_b_we,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_waddr,
    output logic [ELEMENT_WIDTH-1:0]          o_wdata,
    output logic                              o_job_valid,
    input  logic                              i_job_ready,
    output mme_pkg::t_job                     o_job
);
    import mme_pkg::*;

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0] r_rows, r_inner, r_cols;
    logic             r_phase_b;
    logic [IDX_W-1:0] r_row, r_col;
    logic [IDX_W-1:0] n_row, n_col;
    logic             n_phase_b;
    t_job             cur_job;
    logic             row_end, col_end, push;

    // job queue, two entries
    t_job             r_q [2];
    logic             r_wptr, r_rptr;
    logic [1:0]       r_cnt;
    logic             pop;

    assign cur_job.rows  = clamp_dim(r_rows, DIM_LIM);
    assign cur_job.inner = clamp_dim(r_inner, DIM_LIM);
    assign cur_job.cols  = clamp_dim(r_cols, DIM_LIM);

    // position bookkeeping within the current matrix
    always_comb begin
        if (r_phase_b) begin
            col_end = (DIM_W'(r_col) == cur_job.cols - DIM_W'(1));
            row_end = (DIM_W'(r_row) == cur_job.inner - DIM_W'(1));
        end else begin
            col_end = (DIM_W'(r_col) == cur_job.inner - DIM_W'(1));
            row_end = (DIM_W'(r_row) == cur_job.rows - DIM_W'(1));
        end
        push      = i_accept && r_phase_b && col_end && row_end;
        n_row     = r_row;
        n_col     = r_col + IDX_W'(1);
        n_phase_b = r_phase_b;
        if (col_end) begin
            n_col = '0;
            n_row = r_row + IDX_W'(1);
            if (row_end) begin
                n_row     = '0;
                n_phase_b = !r_phase_b;
            end
        end
    end

    // store write port
    assign o_a_we  = i_accept && !r_phase_b;
    assign o_b_we  = i_accept && r_phase_b;
    assign o_waddr = ADDR_W'(r_row) * ADDR_W'(MAX_DIM) + ADDR_W'(r_col);
    assign o_wdata = i_element;

    // configuration and load counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= DIM_RESET;
            r_inner   <= DIM_RESET;
            r_cols    <= DIM_RESET;
            r_phase_b <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
        end else if (i_cfg_we && (i_cfg_index == REG_ROWS_A ||
                     i_cfg_index == REG_INNER_SIZE || i_cfg_index == REG_COLS_B)) begin
            unique case (i_cfg_index)
                REG_ROWS_A:     r_rows  <= i_cfg_data;
                REG_INNER_SIZE: r_inner <= i_cfg_data;
                default:        r_cols  <= i_cfg_data;
            endcase
            r_phase_b <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
        end else if (i_accept) begin
            r_phase_b <= n_phase_b;
            r_row     <= n_row;
            r_col     <= n_col;
        end
    end

    // job queue
    assign pop         = (r_cnt != 2'd0) && i_job_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cur_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

>>> sv/mme_compute.sv
// ----------------------------------------------------------------------------
// mme_compute
// Back end: walks C row-major, one multiply-accumulate per cycle through a
// read / multiply / accumulate pipeline, and emits each finished dot product.
// ----------------------------------------------------------------------------
module mme_compute #(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_valid,
    output logic                               o_job_ready,
    input  mme_pkg::t_job                      i_job,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_a_raddr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_b_raddr,
    input  logic [ELEMENT_WIDTH-1:0]           i_a_rdata,
    input  logic [ELEMENT_WIDTH-1:0]           i_b_rdata,
    output logic                               o_busy,
    output logic                               o_valid,
    output logic [mme_pkg::OUT_W-1:0]          o_product_element,
    output logic [mme_pkg::OUT_IDX_W-1:0]      o_row,
    output logic [mme_pkg::OUT_IDX_W-1:0]      o_col,
    output logic                               o_last
);
    import mme_pkg::*;

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int PW     = 2 * ELEMENT_WIDTH;
    localparam int EXT_W  = (PW > OUT_W) ? PW : OUT_W;

    // per-step control carried down the pipeline
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastl;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    t_job             r_job;
    logic             r_active;
    logic [IDX_W-1:0] r_i, r_j, r_l;
    logic             i_end, j_end, l_end;
    t_tag             tag0, r_tag1, r_tag2;
    logic signed [PW-1:0]    n_prod, r_prod;
    logic signed [EXT_W-1:0] prod_ext;
    logic [OUT_W-1:0] r_acc, n_sum;
    logic             r_valid, r_last;
    logic [OUT_W-1:0] r_out;
    logic [IDX_W-1:0] r_orow, r_ocol;

    assign o_job_ready = !r_active;

    assign l_end = (DIM_W'(r_l) == r_job.inner - DIM_W'(1));
    assign j_end = (DIM_W'(r_j) == r_job.cols - DIM_W'(1));
    assign i_end = (DIM_W'(r_i) == r_job.rows - DIM_W'(1));

    // read issue
    assign o_a_raddr = ADDR_W'(r_i) * ADDR_W'(MAX_DIM) + ADDR_W'(r_l);
    assign o_b_raddr = ADDR_W'(r_l) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j);

    always_comb begin
        tag0.valid = r_active;
        tag0.first = (r_l == '0);
        tag0.lastl = l_end;
        tag0.last  = l_end && j_end && i_end;
        tag0.row   = r_i;
        tag0.col   = r_j;
    end

    // index sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_l      <= '0;
        end else if (!r_active) begin
            if (i_job_valid) begin
                r_active <= 1'b1;
                r_i      <= '0;
                r_j      <= '0;
                r_l      <= '0;
            end
        end else begin
            r_l <= r_l + IDX_W'(1);
            if (l_end) begin
                r_l <= '0;
                r_j <= r_j + IDX_W'(1);
                if (j_end) begin
                    r_j <= '0;
                    r_i <= r_i + IDX_W'(1);
                    if (i_end) begin
                        r_active <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_active && i_job_valid) begin
            r_job <= i_job;
        end
    end

    // multiply and accumulate
    assign n_prod   = $signed(i_a_rdata) * $signed(i_b_rdata);
    assign prod_ext = EXT_W'(r_prod);
    assign n_sum    = (r_tag2.first ? '0 : r_acc) + prod_ext[OUT_W-1:0];

    // pipeline: valid bits reset, tag and product fields free-running, result registers load on a valid step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_tag1.valid <= tag0.valid;
            r_tag2.valid <= r_tag1.valid;
            r_valid      <= r_tag2.valid && r_tag2.lastl;
        end
        r_tag1.first <= tag0.first;
        r_tag1.lastl <= tag0.lastl;
        r_tag1.last  <= tag0.last;
        r_tag1.row   <= tag0.row;
        r_tag1.col   <= tag0.col;
        r_tag2.first <= r_tag1.first;
        r_tag2.lastl <= r_tag1.lastl;
        r_tag2.last  <= r_tag1.last;
        r_tag2.row   <= r_tag1.row;
        r_tag2.col   <= r_tag1.col;
        r_prod       <= n_prod;
        if (r_tag2.valid) begin
            r_acc  <= n_sum;
            r_out  <= n_sum;
            r_last <= r_tag2.last;
            r_orow <= r_tag2.row;
            r_ocol <= r_tag2.col;
        end
    end

    assign o_busy            = r_active || r_tag1.valid || r_tag2.valid || r_valid;
    assign o_valid           = r_valid;
    assign o_product_element = r_out;
    assign o_row             = OUT_IDX_W'(r_orow);
    assign o_col             = OUT_IDX_W'(r_ocol);
    assign o_last            = r_last;
endmodule
